FILE: rtl/pfa_pkg.sv
// pfa_pkg: widths, shared types and helper functions of the packed field array.
// No dependencies; used by pfa_merge, the top level and the testbench.
`default_nettype none
package pfa_pkg;

  localparam int DATA_W      = 64;
  localparam int IDX_W       = 16;
  localparam int FW_W        = 7;
  localparam int POS_W       = IDX_W + FW_W;
  localparam int WIDX_W      = POS_W - 6;
  localparam int STORE_WORDS_DEF = 1024;
  localparam logic [FW_W-1:0] FW_RESET = FW_W'(64);

  typedef struct packed {
    logic            a0;
    logic            spans;
    logic [5:0]      da;
    logic [FW_W-1:0] w;
  } pfa_pos_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_MERGE = 4'b1000
  } pfa_state_e;

  function automatic logic [FW_W-1:0] eff_width(input logic [FW_W-1:0] fw);
    logic [FW_W-1:0] r;
    if (fw == '0) begin
      r = FW_W'(1);
    end else if (fw > FW_W'(64)) begin
      r = FW_W'(64);
    end else begin
      r = fw;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] low_mask(input logic [FW_W-1:0] w);
    logic [DATA_W-1:0] m;
    if (w >= FW_W'(64)) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << w[5:0]) - DATA_W'(1);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pfa_ram.sv
// pfa_ram: generic single-port synchronous ram, registered read.
// No dependencies.
`default_nettype none
module pfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic                                     re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/pfa_merge.sv
// pfa_merge: extracts an entry from its one or two words and merges a new value back.
// Depends on pfa_pkg.
`default_nettype none
module pfa_merge (
  input  wire pfa_pkg::pfa_pos_t           pos_i,
  input  wire logic [pfa_pkg::DATA_W-1:0]  even_rdata_i,
  input  wire logic [pfa_pkg::DATA_W-1:0]  odd_rdata_i,
  input  wire logic [pfa_pkg::DATA_W-1:0]  wval_i,
  output logic      [pfa_pkg::DATA_W-1:0]  rd_value_o,
  output logic      [pfa_pkg::DATA_W-1:0]  even_wdata_o,
  output logic      [pfa_pkg::DATA_W-1:0]  odd_wdata_o
);
  import pfa_pkg::*;

  logic [DATA_W-1:0] lo, hi, mask, v, lo_new, hi_new, ext, hmask;
  logic [FW_W-1:0]   wa, wb;

  always_comb begin
    lo    = pos_i.a0 ? odd_rdata_i : even_rdata_i;
    hi    = pos_i.a0 ? even_rdata_i : odd_rdata_i;
    mask  = low_mask(pos_i.w);
    wa    = FW_W'(64) - FW_W'(pos_i.da);
    wb    = pos_i.w - wa;
    hmask = low_mask(wb);
    // upper word only contributes when spanning, so da is 1..63 there
    ext   = pos_i.spans ? (hi << wa[5:0]) : '0;
    rd_value_o = ((lo >> pos_i.da) | ext) & mask;
    v      = wval_i & mask;
    lo_new = (lo & ~(mask << pos_i.da)) | (v << pos_i.da);
    hi_new = (hi & ~hmask) | (v >> wa[5:0]);
    even_wdata_o = pos_i.a0 ? hi_new : lo_new;
    odd_wdata_o  = pos_i.a0 ? lo_new : hi_new;
  end

endmodule
`default_nettype wire

FILE: rtl/packed_field_array_access.sv
// packed_field_array_access: top level, control sequencer and two word banks.
// Depends on pfa_pkg, pfa_ram and pfa_merge.
//
// channel   | signals                                      | dir
// request   | start_i, busy_o, mode_i, entry_index_i,      | in
//           | write_value_i                                |
// result    | done_o, read_value_o, out_of_range_o         | out
// config    | cfg_we_i, cfg_data_i (field_width)           | in
//
// items are handled one at a time: accept, address calc, bank read, merge and write-back;
// the result strobe comes in the cycle after write-back, when the next start
// can already be taken. even and odd words sit in separate banks so a spanning
// entry reads and writes both words at once. reset clears control and sets the
// field width to 64; word contents are undefined until written. no stall on results.
`default_nettype none
module packed_field_array_access #(
  parameter int STORE_WORDS = pfa_pkg::STORE_WORDS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          mode_i,
  input  wire logic [pfa_pkg::IDX_W-1:0]     entry_index_i,
  input  wire logic [pfa_pkg::DATA_W-1:0]    write_value_i,
  output logic                               done_o,
  output logic      [pfa_pkg::DATA_W-1:0]    read_value_o,
  output logic                               out_of_range_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [pfa_pkg::FW_W-1:0]      cfg_data_i
);
  import pfa_pkg::*;

  localparam int EV_DEPTH = (STORE_WORDS + 1) / 2;
  localparam int OD_DEPTH = STORE_WORDS / 2;
  localparam int EV_AW    = EV_DEPTH > 1 ? $clog2(EV_DEPTH) : 1;
  localparam int OD_AW    = OD_DEPTH > 1 ? $clog2(OD_DEPTH) : 1;

  pfa_state_e         state_q, state_d;
  logic [FW_W-1:0]    fw_q;
  logic               mode_q;
  logic [IDX_W-1:0]   idx_q;
  logic [DATA_W-1:0]  wval_q;
  logic [WIDX_W-1:0]  a_q, a_d;
  pfa_pos_t           pos_q, pos_d;
  logic               oor_q, oor_d;
  logic               done_q;
  logic [DATA_W-1:0]  rv_q, rv_d;
  logic               rof_q;

  logic [FW_W-1:0]    w;
  logic [POS_W-1:0]   first, last;
  logic [WIDX_W-1:0]  b;
  logic [31:0]        ev_full, od_full;
  logic [EV_AW-1:0]   ev_addr;
  logic [OD_AW-1:0]   od_addr;
  logic               ev_use, od_use, ev_re, od_re, ev_we, od_we;
  logic [DATA_W-1:0]  ev_rdata, od_rdata, ev_wdata, od_wdata, merged;

  always_comb begin
    w     = eff_width(fw_q);
    first = POS_W'(idx_q) * POS_W'(w);
    last  = first + POS_W'(w) - POS_W'(1);
    a_d   = first[POS_W-1:6];
    b     = last[POS_W-1:6];
    pos_d.a0    = a_d[0];
    pos_d.spans = (a_d != b);
    pos_d.da    = first[5:0];
    pos_d.w     = w;
    oor_d = (32'(b) >= 32'(STORE_WORDS));
  end

  always_comb begin
    od_full = 32'(a_q[WIDX_W-1:1]);
    ev_full = od_full + 32'(a_q[0]);
    ev_addr = ev_full[EV_AW-1:0];
    od_addr = od_full[OD_AW-1:0];
    ev_use  = !oor_q && (!pos_q.a0 || pos_q.spans);
    od_use  = !oor_q && (pos_q.a0 || pos_q.spans);
    ev_re   = (state_q == ST_READ) && ev_use;
    od_re   = (state_q == ST_READ) && od_use;
    ev_we   = (state_q == ST_MERGE) && mode_q && ev_use;
    od_we   = (state_q == ST_MERGE) && mode_q && od_use;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_CALC;
      ST_CALC:  state_d = ST_READ;
      ST_READ:  state_d = ST_MERGE;
      ST_MERGE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    rv_d = (!mode_q && !oor_q) ? merged : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fw_q    <= FW_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_MERGE);
      if (cfg_we_i) begin
        fw_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      mode_q <= mode_i;
      idx_q  <= entry_index_i;
      wval_q <= write_value_i;
    end
    if (state_q == ST_CALC) begin
      a_q   <= a_d;
      pos_q <= pos_d;
      oor_q <= oor_d;
    end
    if (state_q == ST_MERGE) begin
      rv_q  <= rv_d;
      rof_q <= oor_q;
    end
  end

  pfa_ram #(.WIDTH(DATA_W), .DEPTH(EV_DEPTH)) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .re_i    (ev_re),
    .addr_i  (ev_addr),
    .wdata_i (ev_wdata),
    .rdata_o (ev_rdata)
  );

  pfa_ram #(.WIDTH(DATA_W), .DEPTH(OD_DEPTH)) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .re_i    (od_re),
    .addr_i  (od_addr),
    .wdata_i (od_wdata),
    .rdata_o (od_rdata)
  );

  pfa_merge u_merge (
    .pos_i        (pos_q),
    .even_rdata_i (ev_rdata),
    .odd_rdata_i  (od_rdata),
    .wval_i       (wval_q),
    .rd_value_o   (merged),
    .even_wdata_o (ev_wdata),
    .odd_wdata_o  (od_wdata)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign read_value_o   = rv_q;
  assign out_of_range_o = rof_q;

  a_done_after_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_MERGE))
    else $error("result strobe without a merge cycle");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (read_value_o == '0))
    else $error("out of range beat carries data");

  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_CALC))
    else $error("accepted beat not processed");

  a_no_write_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_we || od_we) |-> (!oor_q && mode_q))
    else $error("bank written on a read or out of range beat");

endmodule
`default_nettype wire

FILE: sim/tb.sv
// tb: self-checking testbench for packed_field_array_access, a bit-packed integer array
// with per-entry read and write. Depends on pfa_pkg and the rtl top level; a local model
// of the store predicts results the directed rows do not give, checked in order of acceptance.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS = pfa_pkg::STORE_WORDS_DEF;

  typedef enum bit {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } access_op_e;

  typedef enum bit {
    ROW_ACCESS = 1'b0,
    ROW_WIDTH  = 1'b1
  } row_kind_e;

  typedef struct {
    logic [pfa_pkg::DATA_W-1:0] value;
    logic                       oor;
  } access_result_t;

  typedef struct {
    row_kind_e                  kind;
    logic [pfa_pkg::FW_W-1:0]   width;
    access_op_e                 op;
    logic [pfa_pkg::IDX_W-1:0]  idx;
    logic [pfa_pkg::DATA_W-1:0] wv;
    bit                         typed;
    access_result_t             res;
  } dir_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       mode_i;
  logic [pfa_pkg::IDX_W-1:0]  entry_index_i;
  logic [pfa_pkg::DATA_W-1:0] write_value_i;
  logic                       done_o;
  logic [pfa_pkg::DATA_W-1:0] read_value_o;
  logic                       out_of_range_o;
  logic                       cfg_we_i;
  logic [pfa_pkg::FW_W-1:0]   cfg_data_i;

  logic [pfa_pkg::DATA_W-1:0] store_img   [WORDS];
  logic [pfa_pkg::DATA_W-1:0] written_img [WORDS];
  logic [pfa_pkg::FW_W-1:0]   width_reg;
  access_result_t             access_results_q[$];
  dir_row_t                   dir_rows[$];
  int                         recent_idx[$];
  int                         errors = 0;
  int                         n_reads = 0;
  int                         n_writes = 0;
  int                         n_oor = 0;
  int                         n_widths = 0;

  packed_field_array_access #(
    .STORE_WORDS(WORDS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .entry_index_i  (entry_index_i),
    .write_value_i  (write_value_i),
    .done_o         (done_o),
    .read_value_o   (read_value_o),
    .out_of_range_o (out_of_range_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int bits_per_entry(input logic [pfa_pkg::FW_W-1:0] fw);
    if (fw == '0) begin
      return 1;
    end
    if (fw > 7'd64) begin
      return 64;
    end
    return int'(fw);
  endfunction

  function automatic logic [63:0] ones(input int n);
    if (n >= 64) begin
      return '1;
    end
    return (64'd1 << n) - 64'd1;
  endfunction

  // word pair and bit offset of one entry at the current width
  function automatic void locate(input logic [15:0] idx, output int w, output int a,
                                 output int b, output int da, output bit spans);
    int first;
    w = bits_per_entry(width_reg);
    first = int'(idx) * w;
    a = first >> 6;
    b = (first + w - 1) >> 6;
    da = first & 63;
    spans = (a != b);
  endfunction

  function automatic bit entry_defined(input logic [15:0] idx);
    int w, a, b, da;
    bit spans;
    logic [63:0] bits;
    locate(idx, w, a, b, da, spans);
    if (b >= WORDS) begin
      return 1'b1;
    end
    bits = written_img[a] >> da;
    if (spans) begin
      bits |= written_img[b] << (64 - da);
    end
    return (bits & ones(w)) == ones(w);
  endfunction

  function automatic access_result_t predict_access(input access_op_e op,
                                                     input logic [15:0] idx,
                                                     input logic [63:0] wv);
    access_result_t res;
    int w, a, b, da, wa;
    bit spans;
    logic [63:0] mask, v, hi_mask;
    locate(idx, w, a, b, da, spans);
    mask = ones(w);
    res.value = '0;
    res.oor = 1'b0;
    if (b >= WORDS) begin
      res.oor = 1'b1;
      return res;
    end
    if (op == OP_READ) begin
      v = store_img[a] >> da;
      if (spans) begin
        v |= store_img[b] << (64 - da);
      end
      res.value = v & mask;
    end else begin
      v = wv & mask;
      store_img[a] = (store_img[a] & ~(mask << da)) | (v << da);
      written_img[a] |= mask << da;
      if (spans) begin
        wa = 64 - da;
        hi_mask = ones(w - wa);
        store_img[b] = (store_img[b] & ~hi_mask) | (v >> wa);
        written_img[b] |= hi_mask;
      end
    end
    return res;
  endfunction

  function automatic void put_row(input row_kind_e kind, input logic [6:0] width,
                                  input access_op_e op, input logic [15:0] idx,
                                  input logic [63:0] wv, input bit typed,
                                  input logic [63:0] val, input logic oor);
    dir_row_t r;
    r.kind = kind;
    r.width = width;
    r.op = op;
    r.idx = idx;
    r.wv = wv;
    r.typed = typed;
    r.res.value = val;
    r.res.oor = oor;
    dir_rows.push_back(r);
  endfunction

  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // holds start until the beat is taken, then records the predicted or directed result
  task automatic issue(input access_op_e op, input logic [15:0] idx, input logic [63:0] wv,
                       input bit typed, input access_result_t typed_res);
    access_result_t res;
    start_i <= 1'b1;
    mode_i <= op;
    entry_index_i <= idx;
    write_value_i <= wv;
    do @(posedge clk_i); while (busy_o);
    res = predict_access(op, idx, wv);
    if (typed) begin
      res = typed_res;
    end
    access_results_q.push_back(res);
    if (res.oor) begin
      n_oor++;
    end else if (op == OP_READ) begin
      n_reads++;
    end else begin
      n_writes++;
      if (recent_idx.size() >= 64) begin
        void'(recent_idx.pop_front());
      end
      recent_idx.push_back(int'(idx));
    end
  endtask

  task automatic write_width(input logic [6:0] fw);
    start_i <= 1'b0;
    while (access_results_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= fw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg = fw;
    recent_idx.delete();
    n_widths++;
  endtask

  always @(posedge clk_i) begin : check_results
    access_result_t head;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (access_results_q.size() == 0) begin
        $display("%0t: result with none pending: value %h oor %b", $time, read_value_o,
                 out_of_range_o);
        errors++;
      end else begin
        head = access_results_q.pop_front();
        if (read_value_o !== head.value) begin
          $display("%0t: read_value expected %h actual %h", $time, head.value,
                   read_value_o);
          errors++;
        end
        if (out_of_range_o !== head.oor) begin
          $display("%0t: out_of_range expected %b actual %b", $time, head.oor,
                   out_of_range_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [6:0] phase_width[12];
    int phase_idle[4];
    access_result_t none;
    access_op_e op;
    logic [63:0] wv;
    int idx, n_ok, sel, w;
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = 1'b0;
    entry_index_i = '0;
    write_value_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    width_reg = pfa_pkg::FW_RESET;
    for (int i = 0; i < WORDS; i++) begin
      store_img[i] = '0;
      written_img[i] = '0;
    end
    none.value = '0;
    none.oor = 1'b0;

    // width 64 after reset
    put_row(ROW_ACCESS, 0, OP_WRITE, 0, '1, 1, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 0, '0, 1, '1, 0);
    put_row(ROW_ACCESS, 0, OP_WRITE, 1023, '0, 1, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 1023, '1, 1, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 1024, '0, 1, '0, 1);
    put_row(ROW_ACCESS, 0, OP_WRITE, 16'hFFFF, '1, 1, '0, 1);
    put_row(ROW_ACCESS, 0, OP_READ, 1023, '0, 1, '0, 0);
    // width zero acts as one bit
    put_row(ROW_WIDTH, 0, OP_READ, 0, '0, 0, '0, 0);
    put_row(ROW_ACCESS, 0, OP_WRITE, 16'hFFFF, 64'd1, 1, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 16'hFFFF, '0, 1, 64'd1, 0);
    put_row(ROW_ACCESS, 0, OP_WRITE, 5, '1, 1, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 5, '0, 1, 64'd1, 0);
    // oversized width acts as 64
    put_row(ROW_WIDTH, 127, OP_READ, 0, '0, 0, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 0, '0, 0, '0, 0);
    put_row(ROW_ACCESS, 0, OP_WRITE, 3, 64'h0123456789ABCDEF, 1, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 3, '0, 1, 64'h0123456789ABCDEF, 0);
    // entries straddling two words, then widths 65 and 7
    put_row(ROW_WIDTH, 33, OP_READ, 0, '0, 0, '0, 0);
    put_row(ROW_ACCESS, 0, OP_WRITE, 1, '1, 1, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 1, '0, 1, 64'h1_FFFF_FFFF, 0);
    put_row(ROW_ACCESS, 0, OP_WRITE, 0, '0, 1, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 0, '0, 0, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 1984, '0, 0, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 1985, '0, 1, '0, 1);
    put_row(ROW_ACCESS, 0, OP_WRITE, 1985, '1, 1, '0, 1);
    put_row(ROW_WIDTH, 65, OP_READ, 0, '0, 0, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 0, '0, 0, '0, 0);
    put_row(ROW_WIDTH, 7, OP_READ, 0, '0, 0, '0, 0);
    put_row(ROW_ACCESS, 0, OP_WRITE, 9, '1, 1, '0, 0);
    put_row(ROW_ACCESS, 0, OP_READ, 9, '0, 1, 64'h7F, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WIDTH) begin
        write_width(dir_rows[i].width);
      end else begin
        issue(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].wv, dir_rows[i].typed,
              dir_rows[i].res);
      end
    end

    phase_width = '{7'd1, 7'd64, 7'd0, 7'd2, 7'd13, 7'd31, 7'd32, 7'd33, 7'd63, 7'd127,
                    7'd0, 7'd0};
    phase_width[10] = 7'($urandom_range(3, 62));
    phase_width[11] = 7'($urandom_range(65, 126));
    phase_idle = '{0, 54, 0, 6};

    for (int p = 0; p < 12; p++) begin
      write_width(phase_width[p]);
      w = bits_per_entry(width_reg);
      n_ok = 65536 / w;
      for (int i = 0; i < 98; i++) begin
        sender_gap(phase_idle[p % 4]);
        sel = $urandom_range(99);
        op = $urandom_range(1) ? OP_WRITE : OP_READ;
        if (sel < 35 && recent_idx.size() > 0) begin
          idx = recent_idx[$urandom_range(recent_idx.size() - 1)];
          op = ($urandom_range(99) < 85) ? OP_READ : OP_WRITE;
        end else if (sel < 70) begin
          idx = $urandom_range((n_ok < 64 ? n_ok : 64) - 1);
        end else if (sel < 85) begin
          idx = n_ok - 3 + $urandom_range(5);
        end else begin
          idx = $urandom_range(65535);
        end
        if (idx > 65535) begin
          idx = 65535;
        end
        // bits never written must not be read
        if (op == OP_READ && !entry_defined(16'(idx))) begin
          op = OP_WRITE;
        end
        sel = $urandom_range(9);
        wv = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
        issue(op, 16'(idx), wv, 0, none);
      end
    end

    start_i <= 1'b0;
    while (access_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d width settings: %0d reads, %0d writes, %0d out-of-range beats",
             n_widths, n_reads, n_writes, n_oor);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
